FILE: rtl/beam_waist_estimator_unit_assert.svh
// Assertion macros shared by the beam waist estimator RTL.
`ifndef BEAM_WAIST_ESTIMATOR_UNIT_ASSERT_SVH
`define BEAM_WAIST_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BWE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define BWE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bwe_pkg.sv
// Shared constants and types of the beam waist estimator.
`default_nettype none
package bwe_pkg;
   localparam int MAX_GRID_DEF    = 256;
   localparam int SAMPLE_BITS_DEF = 16;

   // e squared in unsigned Q3.16, rounded to nearest
   localparam int          E2_BITS = 19;
   localparam logic [18:0] E2_Q16  = 19'd484249;

   localparam int MAG_BITS      = 32;
   localparam int GRID_BITS     = 9;
   localparam int PITCH_BITS    = 16;
   localparam int COORD_BITS    = 8;
   localparam int WAIST_BITS    = 24;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [0:0] CSR_GRID_SIZE    = 1'b0;
   localparam logic [0:0] CSR_SAMPLE_PITCH = 1'b1;

   localparam logic [8:0]  GRID_RESET  = 9'd256;
   localparam logic [15:0] PITCH_RESET = 16'd256;

   typedef enum logic [1:0] {DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT} dir_type;

   typedef enum logic [2:0] {
      W_IDLE, W_SETUP, W_READ, W_MUL, W_CMP, W_NEXT, W_DONE
   } walk_state_type;

   typedef enum logic [2:0] {
      T_LOAD, T_DRAIN, T_HOLD, T_SEARCH, T_SCALE, T_EMIT
   } top_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } walk_status_type;
endpackage
`default_nettype wire

FILE: rtl/bwe_req_if.sv
// Sample channel: valid/ready handshake with one grid sample per beat.
`default_nettype none
interface bwe_req_if #(parameter int SAMPLE_BITS = bwe_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] ex_real;
   logic signed [SAMPLE_BITS-1:0] ex_imag;
   logic signed [SAMPLE_BITS-1:0] ey_real;
   logic signed [SAMPLE_BITS-1:0] ey_imag;
   logic                          last_sample;

   modport source(output valid, ex_real, ex_imag, ey_real, ey_imag, last_sample,
                  input ready);
   modport sink(input valid, ex_real, ex_imag, ey_real, ey_imag, last_sample,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/bwe_rsp_if.sv
// Result channel: valid/ready handshake with one waist estimate per beat.
`default_nettype none
interface bwe_rsp_if;
   logic        valid;
   logic        ready;
   logic        dominant_field;
   logic [7:0]  peak_row;
   logic [7:0]  peak_col;
   logic [23:0] waist;

   modport source(output valid, dominant_field, peak_row, peak_col, waist,
                  input ready);
   modport sink(input valid, dominant_field, peak_row, peak_col, waist,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/bwe_mag.sv
// Magnitude pipeline, frame counters and peak tracking of both fields.
`default_nettype none
module bwe_mag #(
   parameter int MAX_GRID    = bwe_pkg::MAX_GRID_DEF,
   parameter int SAMPLE_BITS = bwe_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic signed [SAMPLE_BITS-1:0] ex_real,
   input  wire logic signed [SAMPLE_BITS-1:0] ex_imag,
   input  wire logic signed [SAMPLE_BITS-1:0] ey_real,
   input  wire logic signed [SAMPLE_BITS-1:0] ey_imag,
   input  wire logic                          last_sample,
   input  wire logic [bwe_pkg::GRID_BITS-1:0] grid_size,
   input  wire logic                          peak_clear,
   output logic                               wr_en,
   output logic [$clog2(MAX_GRID*MAX_GRID)-1:0] wr_addr,
   output logic [bwe_pkg::MAG_BITS-1:0]       wr_x,
   output logic [bwe_pkg::MAG_BITS-1:0]       wr_y,
   output logic [bwe_pkg::MAG_BITS-1:0]       x_peak,
   output logic [bwe_pkg::MAG_BITS-1:0]       y_peak,
   output logic [$clog2(MAX_GRID*MAX_GRID)-1:0] x_pos,
   output logic [$clog2(MAX_GRID*MAX_GRID)-1:0] y_pos,
   output logic [$clog2(MAX_GRID)-1:0]        x_row,
   output logic [$clog2(MAX_GRID)-1:0]        x_col,
   output logic [$clog2(MAX_GRID)-1:0]        y_row,
   output logic [$clog2(MAX_GRID)-1:0]        y_col,
   output logic [$clog2(MAX_GRID+1)-1:0]      n
);
   localparam int AW   = $clog2(MAX_GRID*MAX_GRID);
   localparam int CW   = $clog2(MAX_GRID*MAX_GRID+1);
   localparam int NW   = $clog2(MAX_GRID+1);
   localparam int RW   = $clog2(MAX_GRID);
   localparam int MW   = 2*SAMPLE_BITS;
   localparam int SUMW = (MW+1 > 33) ? MW+1 : 33;
   localparam int MB   = bwe_pkg::MAG_BITS;

   logic [CW-1:0]   cnt_ff;
   logic [RW-1:0]   row_ff, col_ff;
   logic [NW-1:0]   n_ff, n_clamp, n_cur;
   logic [2*NW-1:0] nn_ff;
   logic            take;

   logic            s1_valid_ff;
   logic [MW-1:0]   sq_xr_ff, sq_xi_ff, sq_yr_ff, sq_yi_ff;
   logic [AW-1:0]   s1_pos_ff;
   logic [RW-1:0]   s1_row_ff, s1_col_ff;
   logic signed [MW-1:0] sq_xr, sq_xi, sq_yr, sq_yi;
   logic [SUMW-1:0] sum_x, sum_y;
   logic [MB-1:0]   mag_x, mag_y;

   logic [MB-1:0]   xpk_ff, ypk_ff;
   logic [AW-1:0]   xpos_ff, ypos_ff;
   logic [RW-1:0]   xrow_ff, xcol_ff, yrow_ff, ycol_ff;

   // grid size in use, clamped to [2, MAX_GRID]
   always_comb begin
      if (32'(grid_size) < 32'd2) begin
         n_clamp = NW'(2);
      end else if (32'(grid_size) > 32'(MAX_GRID)) begin
         n_clamp = NW'(MAX_GRID);
      end else begin
         n_clamp = NW'(grid_size);
      end
      n_cur = (cnt_ff == '0) ? n_clamp : n_ff;
      take  = (cnt_ff == '0) || ((2*NW)'(cnt_ff) < nn_ff);
   end

   // squares of the incoming sample
   assign sq_xr = ex_real * ex_real;
   assign sq_xi = ex_imag * ex_imag;
   assign sq_yr = ey_real * ey_real;
   assign sq_yi = ey_imag * ey_imag;

   // frame counters and stage one
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         n_ff        <= NW'(MAX_GRID);
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && take;
         if (accept) begin
            if (cnt_ff == '0) begin
               n_ff <= n_clamp;
            end
            if (take) begin
               cnt_ff <= cnt_ff + CW'(1);
               if (col_ff == RW'(n_cur - NW'(1))) begin
                  col_ff <= '0;
                  row_ff <= row_ff + RW'(1);
               end else begin
                  col_ff <= col_ff + RW'(1);
               end
            end
            if (last_sample) begin
               cnt_ff <= '0;
               row_ff <= '0;
               col_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      nn_ff <= n_ff * n_ff;
      if (accept && take) begin
         sq_xr_ff  <= sq_xr;
         sq_xi_ff  <= sq_xi;
         sq_yr_ff  <= sq_yr;
         sq_yi_ff  <= sq_yi;
         s1_pos_ff <= cnt_ff[AW-1:0];
         s1_row_ff <= row_ff;
         s1_col_ff <= col_ff;
      end
   end

   // stage two: sum with saturation
   always_comb begin
      sum_x = SUMW'(sq_xr_ff) + SUMW'(sq_xi_ff);
      sum_y = SUMW'(sq_yr_ff) + SUMW'(sq_yi_ff);
      mag_x = (sum_x[SUMW-1:MB] != '0) ? '1 : sum_x[MB-1:0];
      mag_y = (sum_y[SUMW-1:MB] != '0) ? '1 : sum_y[MB-1:0];
   end

   // first strict peak of each field
   always_ff @(posedge clock) begin
      if (reset || peak_clear) begin
         xpk_ff  <= '0;
         ypk_ff  <= '0;
         xpos_ff <= '0;
         ypos_ff <= '0;
         xrow_ff <= '0;
         xcol_ff <= '0;
         yrow_ff <= '0;
         ycol_ff <= '0;
      end else if (s1_valid_ff) begin
         if (mag_x > xpk_ff) begin
            xpk_ff  <= mag_x;
            xpos_ff <= s1_pos_ff;
            xrow_ff <= s1_row_ff;
            xcol_ff <= s1_col_ff;
         end
         if (mag_y > ypk_ff) begin
            ypk_ff  <= mag_y;
            ypos_ff <= s1_pos_ff;
            yrow_ff <= s1_row_ff;
            ycol_ff <= s1_col_ff;
         end
      end
   end

   assign wr_en   = s1_valid_ff;
   assign wr_addr = s1_pos_ff;
   assign wr_x    = mag_x;
   assign wr_y    = mag_y;
   assign x_peak  = xpk_ff;
   assign y_peak  = ypk_ff;
   assign x_pos   = xpos_ff;
   assign y_pos   = ypos_ff;
   assign x_row   = xrow_ff;
   assign x_col   = xcol_ff;
   assign y_row   = yrow_ff;
   assign y_col   = ycol_ff;
   assign n       = n_ff;
endmodule
`default_nettype wire

FILE: rtl/bwe_store.sv
// Magnitude memories of both fields, one write and one registered read port.
`default_nettype none
module bwe_store #(
   parameter int MAX_GRID = bwe_pkg::MAX_GRID_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [$clog2(MAX_GRID*MAX_GRID)-1:0] wr_addr,
   input  wire logic [bwe_pkg::MAG_BITS-1:0]       wr_x,
   input  wire logic [bwe_pkg::MAG_BITS-1:0]       wr_y,
   input  wire logic [$clog2(MAX_GRID*MAX_GRID)-1:0] rd_addr,
   input  wire logic                               rd_sel_y,
   output logic [bwe_pkg::MAG_BITS-1:0]            rd_data
);
   localparam int DEPTH = MAX_GRID*MAX_GRID;

   logic [bwe_pkg::MAG_BITS-1:0] mem_x [DEPTH];
   logic [bwe_pkg::MAG_BITS-1:0] mem_y [DEPTH];
   logic [bwe_pkg::MAG_BITS-1:0] q_x_ff, q_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
      end
      q_x_ff <= mem_x[rd_addr];
      q_y_ff <= mem_y[rd_addr];
   end

   assign rd_data = rd_sel_y ? q_y_ff : q_x_ff;
endmodule
`default_nettype wire

FILE: rtl/bwe_walk.sv
// Crossing search: one threshold compare unit stepped along four directions.
`default_nettype none
`include "beam_waist_estimator_unit_assert.svh"
module bwe_walk #(
   parameter int MAX_GRID = bwe_pkg::MAX_GRID_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [bwe_pkg::MAG_BITS-1:0]         peak,
   input  wire logic [$clog2(MAX_GRID*MAX_GRID)-1:0] pos,
   input  wire logic [$clog2(MAX_GRID)-1:0]          row,
   input  wire logic [$clog2(MAX_GRID)-1:0]          col,
   input  wire logic [$clog2(MAX_GRID+1)-1:0]        n,
   output logic [$clog2(MAX_GRID*MAX_GRID)-1:0]      rd_addr,
   input  wire logic [bwe_pkg::MAG_BITS-1:0]         rd_data,
   output bwe_pkg::walk_status_type                  status,
   output logic [$clog2(4*MAX_GRID)-1:0]             sum
);
   localparam int AW = $clog2(MAX_GRID*MAX_GRID);
   localparam int NW = $clog2(MAX_GRID+1);
   localparam int RW = $clog2(MAX_GRID);
   localparam int SW = $clog2(4*MAX_GRID);
   localparam int MB = bwe_pkg::MAG_BITS;
   localparam int PB = MB + bwe_pkg::E2_BITS;

   bwe_pkg::walk_state_type state_ff, state_in;
   bwe_pkg::dir_type        dir_ff;

   logic [MB-1:0] peak_ff;
   logic [AW-1:0] pos_ff, addr_ff, addr_step;
   logic [RW-1:0] row_ff, col_ff, j_ff, steps_ff, steps_sel;
   logic [NW-1:0] n_ff;
   logic [PB-1:0] prod_ff;
   logic [SW-1:0] sum_ff;
   logic          prev_ff;
   logic          below, hit, at_end;

   // steps available and address stride for the current direction
   always_comb begin
      case (dir_ff)
         bwe_pkg::DIR_UP: begin
            steps_sel = row_ff;
            addr_step = addr_ff - AW'(n_ff);
         end
         bwe_pkg::DIR_DOWN: begin
            steps_sel = RW'(n_ff - NW'(1) - NW'(row_ff));
            addr_step = addr_ff + AW'(n_ff);
         end
         bwe_pkg::DIR_LEFT: begin
            steps_sel = col_ff;
            addr_step = addr_ff - AW'(1);
         end
         default: begin
            steps_sel = RW'(n_ff - NW'(1) - NW'(col_ff));
            addr_step = addr_ff + AW'(1);
         end
      endcase
   end

   // threshold compare: m * e^2 <= peak * 2^16
   always_comb begin
      below  = prod_ff <= PB'({peak_ff, 16'b0});
      hit    = (j_ff != '0) && below && !prev_ff;
      at_end = j_ff == steps_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bwe_pkg::W_IDLE:  if (start) state_in = bwe_pkg::W_SETUP;
         bwe_pkg::W_SETUP: state_in = (steps_sel == '0) ? bwe_pkg::W_NEXT : bwe_pkg::W_READ;
         bwe_pkg::W_READ:  state_in = bwe_pkg::W_MUL;
         bwe_pkg::W_MUL:   state_in = bwe_pkg::W_CMP;
         bwe_pkg::W_CMP:   state_in = (hit || at_end) ? bwe_pkg::W_NEXT : bwe_pkg::W_READ;
         bwe_pkg::W_NEXT: begin
            state_in = (dir_ff == bwe_pkg::DIR_RIGHT) ? bwe_pkg::W_DONE : bwe_pkg::W_SETUP;
         end
         bwe_pkg::W_DONE:  state_in = bwe_pkg::W_IDLE;
         default:          state_in = bwe_pkg::W_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      status.busy = state_ff != bwe_pkg::W_IDLE;
      status.done = state_ff == bwe_pkg::W_DONE;
      rd_addr     = addr_ff;
      sum         = sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bwe_pkg::W_IDLE;
         dir_ff   <= bwe_pkg::DIR_UP;
      end else begin
         state_ff <= state_in;
         if (state_ff == bwe_pkg::W_IDLE) begin
            dir_ff <= bwe_pkg::DIR_UP;
         end else if (state_ff == bwe_pkg::W_NEXT && dir_ff != bwe_pkg::DIR_RIGHT) begin
            dir_ff <= bwe_pkg::dir_type'(dir_ff + 2'd1);
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         bwe_pkg::W_IDLE: begin
            if (start) begin
               peak_ff <= peak;
               pos_ff  <= pos;
               row_ff  <= row;
               col_ff  <= col;
               n_ff    <= n;
               sum_ff  <= '0;
            end
         end
         bwe_pkg::W_SETUP: begin
            steps_ff <= steps_sel;
            j_ff     <= '0;
            addr_ff  <= pos_ff;
         end
         bwe_pkg::W_MUL: begin
            prod_ff <= PB'(rd_data) * PB'(bwe_pkg::E2_Q16);
         end
         bwe_pkg::W_CMP: begin
            if (hit) begin
               sum_ff <= sum_ff + SW'(j_ff - RW'(1));
            end else if (at_end) begin
               sum_ff <= sum_ff + SW'(steps_ff - RW'(1));
            end else begin
               prev_ff <= below;
               j_ff    <= j_ff + RW'(1);
               addr_ff <= addr_step;
            end
         end
         default: begin
         end
      endcase
   end

   `BWE_ASSERT_NOW(a_start_idle, start, state_ff == bwe_pkg::W_IDLE, "walk started while busy")
   `BWE_ASSERT_NOW(a_done_last_dir, state_ff == bwe_pkg::W_DONE, dir_ff == bwe_pkg::DIR_RIGHT, "walk done before last direction")
   `BWE_ASSERT_NOW(a_step_bound, state_ff == bwe_pkg::W_READ, j_ff <= steps_ff, "walk stepped past the grid edge")
endmodule
`default_nettype wire

FILE: rtl/beam_waist_estimator_unit.sv
// Beam waist estimator top level: channels, settings, sequencing and scaling.
//
// Samples arrive on req_chan in row-major order, one per beat, one beat per
// cycle while loading. Squared magnitudes (x and y fields) of each beat
// within the grid are stored and the first strict peak of each field is
// tracked. The beat with last_sample set closes the frame: the larger peak
// (x on a tie) picks the field, and one shared threshold unit walks up,
// down, left and right from the peak to the 1/e^2 crossing of the squared
// magnitude, each grid entry read taking read, multiply and compare steps.
// req_chan is not ready from the last beat until the result is registered.
// A result waiting on a stalled rsp_chan does not block the next frame's
// load; the next search starts only once that result has been taken.
// grid_size is sampled at the first beat of a frame; sample_pitch is used
// at the end of the search. Reset (synchronous, active high) clears peaks,
// counters and handshakes; the stores need no clearing.
`default_nettype none
`include "beam_waist_estimator_unit_assert.svh"
module beam_waist_estimator_unit #(
   parameter int MAX_GRID    = bwe_pkg::MAX_GRID_DEF,
   parameter int SAMPLE_BITS = bwe_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bwe_req_if.sink                                req_chan,
   bwe_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [bwe_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [bwe_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   localparam int AW  = $clog2(MAX_GRID*MAX_GRID);
   localparam int NW  = $clog2(MAX_GRID+1);
   localparam int RW  = $clog2(MAX_GRID);
   localparam int SW  = $clog2(4*MAX_GRID);
   localparam int MB  = bwe_pkg::MAG_BITS;
   localparam int PW  = bwe_pkg::PITCH_BITS + SW;
   localparam int WB  = bwe_pkg::WAIST_BITS;
   localparam int PWX = ((PW-2 > WB) ? PW-2 : WB) + 1;

   bwe_pkg::top_state_type  state_ff, state_in;
   bwe_pkg::walk_status_type walk_stat;

   logic [bwe_pkg::GRID_BITS-1:0]  grid_size_ff;
   logic [bwe_pkg::PITCH_BITS-1:0] pitch_ff;

   logic          req_accept, walk_start;
   logic          wr_en;
   logic [AW-1:0] wr_addr, x_pos, y_pos, rd_addr;
   logic [MB-1:0] wr_x, wr_y, x_peak, y_peak, rd_data;
   logic [RW-1:0] x_row, x_col, y_row, y_col;
   logic [NW-1:0] n;
   logic [SW-1:0] walk_sum;
   logic          pick_y;

   logic          use_y_ff;
   logic [RW-1:0] res_row_ff, res_col_ff;
   logic [PW-1:0] prod_ff;
   logic [PWX-1:0] shifted;

   logic                            rsp_valid_ff;
   logic                            rsp_dom_ff;
   logic [bwe_pkg::COORD_BITS-1:0]  rsp_row_ff, rsp_col_ff;
   logic [WB-1:0]                   rsp_waist_ff;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign pick_y     = y_peak > x_peak;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= bwe_pkg::GRID_RESET;
         pitch_ff     <= bwe_pkg::PITCH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bwe_pkg::CSR_GRID_SIZE:    grid_size_ff <= csr_wdata[bwe_pkg::GRID_BITS-1:0];
            bwe_pkg::CSR_SAMPLE_PITCH: pitch_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bwe_mag #(.MAX_GRID(MAX_GRID), .SAMPLE_BITS(SAMPLE_BITS)) u_mag (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .ex_real     (req_chan.ex_real),
      .ex_imag     (req_chan.ex_imag),
      .ey_real     (req_chan.ey_real),
      .ey_imag     (req_chan.ey_imag),
      .last_sample (req_chan.last_sample),
      .grid_size   (grid_size_ff),
      .peak_clear  (walk_start),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_x        (wr_x),
      .wr_y        (wr_y),
      .x_peak      (x_peak),
      .y_peak      (y_peak),
      .x_pos       (x_pos),
      .y_pos       (y_pos),
      .x_row       (x_row),
      .x_col       (x_col),
      .y_row       (y_row),
      .y_col       (y_col),
      .n           (n)
   );

   bwe_store #(.MAX_GRID(MAX_GRID)) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_x     (wr_x),
      .wr_y     (wr_y),
      .rd_addr  (rd_addr),
      .rd_sel_y (use_y_ff),
      .rd_data  (rd_data)
   );

   bwe_walk #(.MAX_GRID(MAX_GRID)) u_walk (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .peak    (pick_y ? y_peak : x_peak),
      .pos     (pick_y ? y_pos : x_pos),
      .row     (pick_y ? y_row : x_row),
      .col     (pick_y ? y_col : x_col),
      .n       (n),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .status  (walk_stat),
      .sum     (walk_sum)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bwe_pkg::T_LOAD: begin
            if (req_accept && req_chan.last_sample) state_in = bwe_pkg::T_DRAIN;
         end
         bwe_pkg::T_DRAIN:  state_in = bwe_pkg::T_HOLD;
         bwe_pkg::T_HOLD:   if (!rsp_valid_ff) state_in = bwe_pkg::T_SEARCH;
         bwe_pkg::T_SEARCH: if (walk_stat.done) state_in = bwe_pkg::T_SCALE;
         bwe_pkg::T_SCALE:  state_in = bwe_pkg::T_EMIT;
         bwe_pkg::T_EMIT:   state_in = bwe_pkg::T_LOAD;
         default:           state_in = bwe_pkg::T_LOAD;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = state_ff == bwe_pkg::T_LOAD;
      walk_start     = (state_ff == bwe_pkg::T_HOLD) && !rsp_valid_ff;
      shifted        = PWX'(prod_ff >> 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bwe_pkg::T_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == bwe_pkg::T_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result datapath: capture at search start, scale pitch by distance sum
   always_ff @(posedge clock) begin
      if (walk_start) begin
         use_y_ff   <= pick_y;
         res_row_ff <= pick_y ? y_row : x_row;
         res_col_ff <= pick_y ? y_col : x_col;
      end
      if (state_ff == bwe_pkg::T_SCALE) begin
         prod_ff <= PW'(pitch_ff) * PW'(walk_sum);
      end
      if (state_ff == bwe_pkg::T_EMIT) begin
         rsp_dom_ff   <= use_y_ff;
         rsp_row_ff   <= bwe_pkg::COORD_BITS'(res_row_ff);
         rsp_col_ff   <= bwe_pkg::COORD_BITS'(res_col_ff);
         rsp_waist_ff <= (shifted[PWX-1:WB] != '0) ? '1 : shifted[WB-1:0];
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.dominant_field = rsp_dom_ff;
   assign rsp_chan.peak_row       = rsp_row_ff;
   assign rsp_chan.peak_col       = rsp_col_ff;
   assign rsp_chan.waist          = rsp_waist_ff;

   `BWE_ASSERT_NOW(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff) == bwe_pkg::T_EMIT, "result raised outside emit")
   `BWE_ASSERT_NEXT(a_start_search, walk_start, state_ff == bwe_pkg::T_SEARCH, "search did not follow walk start")
   `BWE_ASSERT_NOW(a_done_in_search, walk_stat.done, state_ff == bwe_pkg::T_SEARCH, "walk finished outside search")
endmodule
`default_nettype wire

FILE: tb/sv/beam_waist_estimator_unit_tb.sv
// Self-checking testbench for the beam waist estimator: random grids, bursty input, stalled output.
`default_nettype none
module beam_waist_estimator_unit_tb;

   localparam int STORE_N = bwe_pkg::MAX_GRID_DEF * bwe_pkg::MAX_GRID_DEF;
   localparam logic [63:0] E2_FACTOR = 64'd484249;

   typedef struct {
      logic signed [15:0] xr, xi, yr, yi;
      logic               last;
   } sample_type;

   typedef struct {
      logic        dom;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [23:0] waist;
   } waist_type;

   typedef enum int {
      PAT_NOISE, PAT_BEAM_X, PAT_BEAM_Y, PAT_ZERO, PAT_TIE, PAT_EXTREME, PAT_ORIGIN
   } pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                              csr_we    = 1'b0;
   logic [bwe_pkg::CSR_IDX_BITS-1:0]  csr_index = bwe_pkg::CSR_GRID_SIZE;
   logic [bwe_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   bwe_req_if req_chan();
   bwe_rsp_if rsp_chan();

   beam_waist_estimator_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Stimulus and expectation stores
   sample_type sample_q[$];
   waist_type  waist_q[$];
   int      mismatches = 0;
   logic    req_took = 1'b0;

   // Predictor state
   bit [31:0] x_mag[STORE_N];
   bit [31:0] y_mag[STORE_N];
   bit [31:0] x_pk, y_pk;
   int        x_pos, y_pos, beat_cnt, frame_side;
   bit [8:0]  grid_reg;
   bit [15:0] pitch_reg;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   function automatic bit [31:0] mag_sq(input logic signed [15:0] re, input logic signed [15:0] im);
      longint a, b;
      a = re;
      b = im;
      return 32'(a * a + b * b);
   endfunction

   function automatic bit under_e(input bit [31:0] m, input bit [31:0] pk);
      return ({32'b0, m} * E2_FACTOR) <= ({32'b0, pk} << 16);
   endfunction

   // Distance from the peak to the 1/e^2 crossing of the squared magnitude along one direction
   function automatic int crossing_dist(input bit use_y, input int base, input int stride,
                                        input bit back, input int steps, input bit [31:0] pk);
      int d, cur, nxt;
      bit [31:0] mc, mn;
      d = 0;
      for (int k = 0; k < steps; k++) begin
         cur = back ? base - k * stride : base + k * stride;
         nxt = back ? cur - stride : cur + stride;
         d = k;
         mc = use_y ? y_mag[cur] : x_mag[cur];
         mn = use_y ? y_mag[nxt] : x_mag[nxt];
         if (under_e(mn, pk) && !under_e(mc, pk)) break;
      end
      return d;
   endfunction

   // Absorb one accepted sample beat; queue a waist estimate on the closing beat
   function automatic void absorb_beat(input sample_type s);
      int n, pos, row, col, sum;
      bit use_y;
      bit [31:0] pk, mx, my;
      longint w;
      waist_type e;
      if (beat_cnt == 0) frame_side = grid_reg < 2 ? 2 : (grid_reg > 256 ? 256 : int'(grid_reg));
      n = frame_side;
      if (beat_cnt < n * n) begin
         mx = mag_sq(s.xr, s.xi);
         my = mag_sq(s.yr, s.yi);
         x_mag[beat_cnt] = mx;
         y_mag[beat_cnt] = my;
         if (mx > x_pk) begin x_pk = mx; x_pos = beat_cnt; end
         if (my > y_pk) begin y_pk = my; y_pos = beat_cnt; end
         beat_cnt++;
      end
      if (!s.last) return;
      use_y = y_pk > x_pk;
      pk = use_y ? y_pk : x_pk;
      pos = use_y ? y_pos : x_pos;
      row = pos / n;
      col = pos % n;
      sum = crossing_dist(use_y, pos, n, 1, row, pk)
          + crossing_dist(use_y, pos, n, 0, n - 1 - row, pk)
          + crossing_dist(use_y, pos, 1, 1, col, pk)
          + crossing_dist(use_y, pos, 1, 0, n - 1 - col, pk);
      w = (longint'(pitch_reg) * sum) >>> 2;
      if (w > 64'hFFFFFF) w = 64'hFFFFFF;
      e.dom = use_y;
      e.row = 8'(row);
      e.col = 8'(col);
      e.waist = 24'(w);
      waist_q.push_back(e);
      beat_cnt = 0;
      x_pk = 0;
      y_pk = 0;
      x_pos = 0;
      y_pos = 0;
   endfunction

   // Monitor: results checked before the same edge's input beat is absorbed
   always @(posedge clock) begin
      sample_type s;
      waist_type e;
      if (reset) begin
         x_pk = 0; y_pk = 0; x_pos = 0; y_pos = 0; beat_cnt = 0;
         grid_reg = bwe_pkg::GRID_RESET;
         pitch_reg = bwe_pkg::PITCH_RESET;
         frame_side = 256;
         req_took <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (waist_q.size() == 0) begin
               report("unexpected result beat", 1, 0);
            end else begin
               e = waist_q.pop_front();
               if (rsp_chan.dominant_field !== e.dom) report("dominant_field", rsp_chan.dominant_field, e.dom);
               if (rsp_chan.peak_row !== e.row) report("peak_row", rsp_chan.peak_row, e.row);
               if (rsp_chan.peak_col !== e.col) report("peak_col", rsp_chan.peak_col, e.col);
               if (rsp_chan.waist !== e.waist) report("waist", rsp_chan.waist, e.waist);
            end
         end
         if (csr_we) begin
            if (csr_index == bwe_pkg::CSR_GRID_SIZE) grid_reg = csr_wdata[8:0];
            else pitch_reg = csr_wdata;
         end
         if (req_chan.valid && req_chan.ready) begin
            s.xr = req_chan.ex_real;
            s.xi = req_chan.ex_imag;
            s.yr = req_chan.ey_real;
            s.yi = req_chan.ey_imag;
            s.last = req_chan.last_sample;
            absorb_beat(s);
         end
         req_took <= req_chan.valid && req_chan.ready;
      end
   end

   // Driver: bursts of beats with random gaps
   int burst_left = 4;
   int gap_left = 0;
   always @(negedge clock) begin
      sample_type s;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            s = sample_q.pop_front();
            req_chan.ex_real <= s.xr;
            req_chan.ex_imag <= s.xi;
            req_chan.ey_real <= s.yr;
            req_chan.ey_imag <= s.yi;
            req_chan.last_sample <= s.last;
            req_chan.valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 32);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: switches among always-ready, choppy and long-stall modes
   int rx_mode = 0;
   int rx_left = 0;
   int rx_hold = 0;
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_left = $urandom_range(50, 400);
      end
      rx_left--;
      case (rx_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         default: begin
            if (rx_hold > 0) begin
               rx_hold--;
               rsp_chan.ready <= 1'b0;
            end else begin
               rx_hold = $urandom_range(0, 40);
               rsp_chan.ready <= 1'b1;
            end
         end
      endcase
   end

   task automatic csr_write(input logic [bwe_pkg::CSR_IDX_BITS-1:0] idx, input int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bwe_pkg::CSR_DATA_BITS'(val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sample_q.size() != 0 || req_chan.valid || waist_q.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   // Queue one frame of beats; the last one carries last_sample.
   // The origin pattern puts a lone peak at entry 0, so the search only
   // touches entries 0, 1 and n of the frame.
   task automatic queue_frame(input int n, input pattern_type pat, input int beats);
      sample_type s;
      int r0, c0, wd, amp, r, c, d2, sh, v;
      r0 = $urandom_range(0, n - 1);
      c0 = $urandom_range(0, n - 1);
      wd = $urandom_range(1, n);
      amp = $urandom_range(1, 32767);
      for (int i = 0; i < beats; i++) begin
         r = (i / n) % n;
         c = i % n;
         d2 = (r - r0) * (r - r0) + (c - c0) * (c - c0);
         sh = (d2 * 3) / (wd * wd);
         v = sh > 15 ? 0 : (amp >> sh);
         case (pat)
            PAT_NOISE: begin
               s.xr = 16'($urandom); s.xi = 16'($urandom);
               s.yr = 16'($urandom); s.yi = 16'($urandom);
            end
            PAT_BEAM_X: begin
               s.xr = 16'(v); s.xi = 16'(int'($urandom_range(0, 7)) - 4);
               s.yr = 16'(v >> 2); s.yi = 16'sd0;
            end
            PAT_BEAM_Y: begin
               s.yr = 16'(-v); s.yi = 16'(int'($urandom_range(0, 7)) - 4);
               s.xr = 16'(v >> 2); s.xi = 16'sd0;
            end
            PAT_ZERO: begin
               s.xr = 16'sd0; s.xi = 16'sd0; s.yr = 16'sd0; s.yi = 16'sd0;
            end
            PAT_TIE: begin
               s.xr = 16'(v); s.xi = 16'(-v); s.yr = 16'(-v); s.yi = 16'(v);
            end
            PAT_ORIGIN: begin
               s.xi = 16'sd0; s.yi = 16'sd0;
               if (i == 0) begin
                  s.xr = 16'(amp);
                  s.yr = 16'($urandom_range(1, 32767));
               end else begin
                  s.xr = 16'sd0;
                  s.yr = 16'sd0;
               end
            end
            default: begin
               s.xr = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
               s.xi = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
               s.yr = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
               s.yi = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
            end
         endcase
         s.last = (i == beats - 1);
         sample_q.push_back(s);
      end
   endtask

   // Stimulus sequence
   initial begin
      int sent, n, side, beats, sel, g;
      pattern_type pat;
      req_chan.valid = 1'b0;
      req_chan.ex_real = '0;
      req_chan.ex_imag = '0;
      req_chan.ey_real = '0;
      req_chan.ey_imag = '0;
      req_chan.last_sample = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners at the smallest grid; the first frame fills it
      csr_write(bwe_pkg::CSR_GRID_SIZE, 2);
      csr_write(bwe_pkg::CSR_SAMPLE_PITCH, 65535);
      queue_frame(2, PAT_ZERO, 4);
      queue_frame(2, PAT_TIE, 4);
      queue_frame(2, PAT_EXTREME, 4);
      queue_frame(2, PAT_BEAM_Y, 6);
      wait_idle();
      csr_write(bwe_pkg::CSR_GRID_SIZE, 0);
      csr_write(bwe_pkg::CSR_SAMPLE_PITCH, 0);
      queue_frame(2, PAT_NOISE, 4);
      wait_idle();
      csr_write(bwe_pkg::CSR_GRID_SIZE, 1);
      csr_write(bwe_pkg::CSR_SAMPLE_PITCH, 1);
      queue_frame(2, PAT_BEAM_X, 1);
      wait_idle();
      // Oversized grid setting clamps to the largest grid; close it early
      // once entries 0 through 256 hold fresh values
      csr_write(bwe_pkg::CSR_GRID_SIZE, 511);
      csr_write(bwe_pkg::CSR_SAMPLE_PITCH, 65535);
      queue_frame(256, PAT_ORIGIN, 257);
      wait_idle();

      // Random phases, mostly small grids
      sent = 0;
      while (sent < 1300) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) g = $urandom_range(0, 1);
         else if (sel == 1) g = $urandom_range(257, 511);
         else if (sel == 2) g = $urandom_range(17, 256);
         else g = $urandom_range(2, 8);
         side = g < 2 ? 2 : (g > 256 ? 256 : g);
         csr_write(bwe_pkg::CSR_GRID_SIZE, g);
         sel = $urandom_range(0, 9);
         csr_write(bwe_pkg::CSR_SAMPLE_PITCH,
                   sel == 0 ? 0 : (sel == 1 ? 65535 : $urandom_range(0, 65535)));
         repeat ($urandom_range(1, 4)) begin
            n = side;
            if (n > 16) begin
               // large grids: lone peak at entry 0, closed after entry n
               beats = n + 1;
               pat = PAT_ORIGIN;
            end else begin
               sel = $urandom_range(0, 9);
               if (sel == 0) beats = $urandom_range(1, n * n);
               else if (sel == 1) beats = n * n + $urandom_range(1, 3);
               else beats = n * n;
               sel = $urandom_range(0, 19);
               if (sel < 6) pat = PAT_BEAM_X;
               else if (sel < 12) pat = PAT_BEAM_Y;
               else if (sel < 16) pat = PAT_NOISE;
               else if (sel == 16) pat = PAT_ZERO;
               else if (sel == 17) pat = PAT_TIE;
               else pat = PAT_EXTREME;
            end
            queue_frame(n, pat, beats);
            sent += beats;
         end
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
